// ----- hdl/cfph_pkg.sv -----
// Package with the constants, types and helper functions of the case-folded string hash.
package cfph_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned HASH_W = 30;
    localparam int unsigned TDATA_IN_W = 8;
    localparam int unsigned TDATA_OUT_W = 32;

    localparam logic [HASH_W-1:0] HASH_BASE = 30'd239017;
    localparam logic [HASH_W-1:0] HASH_MOD = 30'd1000000007;
    localparam logic [31:0] HASH_MOD_X2 = 32'd2000000014;

    localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_FOLD = 8'h20;

    localparam int unsigned PW_DEPTH = 4;

    typedef logic [HASH_W-1:0] t_hash;

    function automatic t_hash pow_mod(input int unsigned k);
        longint unsigned v;
        int unsigned i;
        v = 64'd1;
        for (i = 0; i < k; i++) begin
            v = (v * 64'(HASH_BASE)) % 64'(HASH_MOD);
        end
        return t_hash'(v);
    endfunction

    localparam t_hash PW_STEP = pow_mod(PW_DEPTH);
    localparam t_hash PW_INIT1 = pow_mod(1);
    localparam t_hash PW_INIT2 = pow_mod(2);
    localparam t_hash PW_INIT3 = pow_mod(3);

    localparam logic [30:0] HASH_MU = 31'(64'h1000_0000_0000_0000 / 64'(HASH_MOD));

    function automatic t_hash mod_fix(input logic [31:0] r);
        logic [31:0] v;
        if (r >= HASH_MOD_X2) begin
            v = r - HASH_MOD_X2;
        end else if (r >= 32'(HASH_MOD)) begin
            v = r - 32'(HASH_MOD);
        end else begin
            v = r;
        end
        return v[HASH_W-1:0];
    endfunction

endpackage

// ----- hdl/case_folded_polynomial_string_hash.sv -----
// Top level of the case-folded polynomial string hash modulo 1000000007.
//
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] char_byte
// m_axis    out        tdata[29:0] hash_value, tdata[31:30] zero
//
// One byte request is taken per cycle unless stalled; a zero byte's hash is registered out after stage d.
// The running base power cycles through a four-stage multiply and Barrett reduction loop
// that holds four interleaved powers, so it steps once per accepted non-zero byte.
// Synchronous reset empties the pipeline, clears the hash and restarts the power at one.
// The input stalls only while a hash waits on the output and another one reaches the end.
module case_folded_polynomial_string_hash (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [cfph_pkg::TDATA_IN_W-1:0]   i_s_axis_tdata,  // [7:0] char_byte
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [cfph_pkg::TDATA_OUT_W-1:0]  o_m_axis_tdata   // [29:0] hash_value
);
    import cfph_pkg::*;

    logic               w_en;
    logic               w_take;
    logic               w_step;
    logic               w_restart;
    logic [CHAR_W-1:0]  w_chr;

    // Power loop: registers r_pw0, r_pw_p, r_pw_x with r_pw_q, and r_pw_r hold four interleaved powers.
    t_hash              r_pw0;
    logic [59:0]        r_pw_p;
    logic [31:0]        r_pw_x;
    logic [HASH_W-1:0]  r_pw_q;
    logic [31:0]        r_pw_r;
    logic [59:0]        n_pw_p;
    logic [61:0]        w_pw_q2;
    logic [31:0]        w_pw_qm;

    // Data pipeline.
    logic               r_a_vld;
    logic               r_a_end;
    t_hash              r_a_pow;
    logic [CHAR_W-1:0]  r_a_chr;
    logic               r_b_vld;
    logic               r_b_end;
    logic [37:0]        r_b_x;
    logic               r_c_vld;
    logic               r_c_end;
    logic [31:0]        r_c_x;
    logic [7:0]         r_c_q;
    logic               r_d_vld;
    logic               r_d_end;
    logic [31:0]        r_d_r;
    logic [39:0]        w_c_q2;
    logic [31:0]        w_d_qm;

    t_hash              r_acc;
    t_hash              n_acc;
    t_hash              w_term;
    logic [HASH_W:0]    w_sum;

    logic               r_out_vld;
    t_hash              r_out_hash;

    assign w_en = !(r_out_vld && !i_m_axis_tready && r_d_vld && r_d_end);
    assign o_s_axis_tready = w_en;
    assign w_take = i_s_axis_tvalid && w_en;
    assign w_step = w_take && (i_s_axis_tdata != CHAR_NUL);
    assign w_restart = w_take && (i_s_axis_tdata == CHAR_NUL);

    always_comb begin
        if (i_s_axis_tdata inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            w_chr = i_s_axis_tdata + CHAR_FOLD;
        end else begin
            w_chr = i_s_axis_tdata;
        end
    end

    always_comb begin
        n_pw_p = 60'(r_pw0) * 60'(PW_STEP);
        w_pw_q2 = 62'(r_pw_p[59:29]) * 62'(HASH_MU);
        w_pw_qm = 32'(r_pw_q) * 32'(HASH_MOD);
    end

    // On restart the loop is loaded with the first four powers so the next bytes see them in turn.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_restart) begin
            r_pw0 <= t_hash'(1);
            r_pw_p <= 60'(PW_INIT3);
            r_pw_x <= 32'(PW_INIT2);
            r_pw_q <= '0;
            r_pw_r <= 32'(PW_INIT1);
        end else if (w_step) begin
            r_pw0 <= mod_fix(r_pw_r);
            r_pw_p <= n_pw_p;
            r_pw_x <= r_pw_p[31:0];
            r_pw_q <= w_pw_q2[60:31];
            r_pw_r <= r_pw_x - w_pw_qm;
        end
    end

    always_comb begin
        w_c_q2 = 40'(r_b_x[37:29]) * 40'(HASH_MU);
        w_d_qm = 32'(r_c_q) * 32'(HASH_MOD);
        w_term = mod_fix(r_d_r);
        w_sum = {1'b0, r_acc} + {1'b0, w_term};
        if (w_sum >= {1'b0, HASH_MOD}) begin
            n_acc = t_hash'(w_sum - {1'b0, HASH_MOD});
        end else begin
            n_acc = w_sum[HASH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_s_axis_tvalid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_end <= (i_s_axis_tdata == CHAR_NUL);
            r_a_pow <= r_pw0;
            r_a_chr <= w_chr;
            r_b_end <= r_a_end;
            r_b_x <= 38'(r_a_pow) * 38'(r_a_chr);
            r_c_end <= r_b_end;
            r_c_x <= r_b_x[31:0];
            r_c_q <= w_c_q2[38:31];
            r_d_end <= r_c_end;
            r_d_r <= r_c_x - w_d_qm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (w_en && r_d_vld) begin
            if (r_d_end) begin
                r_acc <= '0;
            end else begin
                r_acc <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en && r_d_vld && r_d_end) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_d_vld && r_d_end) begin
            r_out_hash <= r_acc;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata = {(TDATA_OUT_W - HASH_W)'(0), r_out_hash};

endmodule

// ----- tb/tb_case_folded_polynomial_string_hash.sv -----
// Testbench for the case-folded string hash, checking each hash against a built-in model.
`timescale 1ns / 1ps

module tb_case_folded_polynomial_string_hash;
    import cfph_pkg::*;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [TDATA_IN_W-1:0]  i_s_axis_tdata;   // [7:0] char_byte
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [TDATA_OUT_W-1:0] o_m_axis_tdata;   // [29:0] hash_value, [31:30] zero

    t_hash       hash_acc;
    t_hash       hash_pow;
    t_hash       pending_hashes[$];
    int unsigned burst_left;
    int unsigned chars_sent;
    int unsigned error_count;
    bit          hold_off_req;

    case_folded_polynomial_string_hash u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 50) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    // Each request is offered in bursts; the model is updated when the byte is accepted.
    task automatic send_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] folded;
        longint unsigned   sum;
        if (burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= TDATA_IN_W'($urandom);
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        do @(posedge i_clk); while (!o_s_axis_tready);
        burst_left--;
        chars_sent++;
        if (c == CHAR_NUL) begin
            pending_hashes.push_back(hash_acc);
            hash_acc = '0;
            hash_pow = t_hash'(1);
        end else begin
            folded = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CHAR_FOLD : c;
            sum = 64'(hash_acc) + 64'(hash_pow) * 64'(folded);
            hash_acc = t_hash'(sum % 64'(HASH_MOD));
            hash_pow = t_hash'((64'(hash_pow) * 64'(HASH_BASE)) % 64'(HASH_MOD));
        end
    endtask

    task automatic send_string(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            send_char(s[i]);
        end
        send_char(CHAR_NUL);
    endtask

    function automatic logic [CHAR_W-1:0] pick_char();
        logic [CHAR_W-1:0] c;
        case ($urandom_range(0, 3))
            0: c = CHAR_UPPER_A + CHAR_W'($urandom_range(0, 25));
            1: c = CHAR_UPPER_A + CHAR_FOLD + CHAR_W'($urandom_range(0, 25));
            2: c = CHAR_W'($urandom_range(1, 255));
            default: begin
                case ($urandom_range(0, 7))
                    0: c = CHAR_UPPER_A - 8'd1;
                    1: c = CHAR_UPPER_A;
                    2: c = CHAR_UPPER_Z;
                    3: c = CHAR_UPPER_Z + 8'd1;
                    4: c = CHAR_UPPER_A + CHAR_FOLD - 8'd1;
                    5: c = CHAR_UPPER_Z + CHAR_FOLD + 8'd1;
                    6: c = 8'h80;
                    default: c = 8'hFF;
                endcase
            end
        endcase
        return c;
    endfunction

    task automatic test_empty_string();
        send_char(CHAR_NUL);
        send_char(CHAR_NUL);
    endtask

    task automatic test_case_folding();
        send_string("AZaz");
        send_string("@[`{");
        send_string("Hi");
        send_string("hI");
    endtask

    task automatic test_high_bytes();
        send_char(8'h80);
        send_char(8'hFF);
        send_char(8'h01);
        send_char(8'h7F);
        send_char(CHAR_NUL);
    endtask

    // The receiver holds off while the sender keeps offering short strings without gaps.
    task automatic test_output_pressure();
        int unsigned i;
        hold_off_req = 1'b1;
        burst_left = 200;
        for (i = 0; i < 40; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                send_char(pick_char());
            end
            send_char(CHAR_NUL);
        end
    endtask

    task automatic test_random_strings();
        int unsigned start;
        int unsigned len;
        int unsigned i;
        start = chars_sent;
        while (chars_sent - start < 1350) begin
            case ($urandom_range(0, 19))
                0: len = 0;
                1: len = $urandom_range(50, 300);
                default: len = $urandom_range(1, 12);
            endcase
            for (i = 0; i < len; i++) begin
                send_char(pick_char());
            end
            send_char(CHAR_NUL);
        end
    endtask

    // The receiver stalls in phases of its own, with a long hold-off on request.
    initial begin
        int unsigned mode;
        int unsigned phase;
        i_m_axis_tready <= 1'b0;
        mode = 0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else begin
                if (phase == 0) begin
                    mode = $urandom_range(0, 3);
                    phase = $urandom_range(20, 100);
                end
                phase--;
                case (mode)
                    0: i_m_axis_tready <= 1'b1;
                    1: i_m_axis_tready <= 1'($urandom_range(0, 1));
                    2: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: i_m_axis_tready <= (phase % 3 != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_hashes.size() == 0) begin
                report_mismatch($sformatf("unexpected hash %0d", o_m_axis_tdata));
            end else begin
                if (o_m_axis_tdata !== TDATA_OUT_W'(pending_hashes[0])) begin
                    report_mismatch($sformatf("hash_value got %0d, expected %0d",
                                              o_m_axis_tdata, pending_hashes[0]));
                end
                void'(pending_hashes.pop_front());
            end
        end
    end

    initial begin
        int unsigned guard;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        hash_acc    = '0;
        hash_pow    = t_hash'(1);
        burst_left  = 0;
        chars_sent  = 0;
        error_count = 0;
        hold_off_req = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_string();
        test_case_folding();
        test_high_bytes();
        test_output_pressure();
        test_random_strings();

        i_s_axis_tvalid <= 1'b0;
        guard = 0;
        while (pending_hashes.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (pending_hashes.size() != 0) begin
            report_mismatch($sformatf("%0d hashes never delivered", pending_hashes.size()));
        end

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
